// ===== src/matrix_keyboard_decoder_top_macros.svh =====
// Assertion macros for the key matrix decoder, used by the result register module.
`ifndef MATRIX_KEYBOARD_DECODER_TOP_MACROS_SVH
`define MATRIX_KEYBOARD_DECODER_TOP_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define MKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/mkd_pkg.sv =====
// Package with key tables, codes and the result record type of the key matrix decoder.
`timescale 1ns / 1ps
package mkd_pkg;

  localparam int LINE_COUNT_BITS_DEF = 16;

  localparam logic [2:0] COL_FIRST = 3'd1;
  localparam logic [2:0] COL_LAST  = 3'd5;
  localparam logic [3:0] ROW_LAST  = 4'd6;

  // Key codes above the ASCII range, and KC_NONE for no code.
  localparam logic [7:0] KC_SHIFT = 8'h80;
  localparam logic [7:0] KC_DEL   = 8'h81;
  localparam logic [7:0] KC_ALT   = 8'h82;
  localparam logic [7:0] KC_NOP   = 8'h83;
  localparam logic [7:0] KC_ENTER = 8'h84;
  localparam logic [7:0] KC_NONE  = 8'h00;

  localparam logic [7:0] CH_BS = 8'h08;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // What one input leaves for the output side.
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_ENTER = 2'd2;
  localparam logic [1:0] KIND_DEL   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chr;
    logic [2:0] column;
    logic       shift;
    logic       alt;
  } rec_t;

  localparam logic [7:0] BASE_TBL [0:6][0:4] = '{
    '{"q", "e", "r", "u", "o"},
    '{"w", "s", "g", "h", "l"},
    '{KC_NOP, "d", "t", "y", "i"},
    '{"a", "p", KC_SHIFT, KC_ENTER, KC_DEL},
    '{KC_ALT, "x", "v", "b", "$"},
    '{" ", "z", "c", "n", "m"},
    '{KC_NOP, KC_SHIFT, "f", "j", "k"}
  };

  // A zero entry means the key has no alt meaning.
  localparam logic [7:0] ALT_TBL [0:6][0:4] = '{
    '{"#", "2", "3", "_", "+"},
    '{"1", "4", "/", ":", "\""},
    '{KC_NONE, "5", "(", ")", "-"},
    '{"*", "@", KC_NONE, KC_NONE, KC_NONE},
    '{KC_NONE, "8", "?", "!", KC_NONE},
    '{KC_NONE, "7", "9", ",", "."},
    '{"0", KC_NONE, "6", ";", "'"}
  };

  function automatic logic [7:0] base_code(input logic [2:0] row, input logic [2:0] col);
    logic [7:0] code;
    code = KC_NOP;
    if (row <= 3'd6 && col <= 3'd4) begin
      code = BASE_TBL[row][col];
    end
    return code;
  endfunction

  function automatic logic [7:0] alt_code(input logic [2:0] row, input logic [2:0] col);
    logic [7:0] code;
    code = KC_NONE;
    if (row <= 3'd6 && col <= 3'd4) begin
      code = ALT_TBL[row][col];
    end
    return code;
  endfunction

endpackage

// ===== src/matrix_keyboard_decoder_top.sv =====
// Top level of the key matrix decoder.
// Each input beat (scan tick or row edge) is decoded in the cycle it is accepted and its
// result lands in a single result register, which sends one beat per byte: one beat for a
// tick, an ignored edge, a modifier or no-op key or a delete on an empty line, one for a
// character, two for enter and three for delete. A new input beat is accepted in the same
// cycle the last result beat of the previous one leaves; with no output stall ticks run at
// one per cycle.
`timescale 1ns / 1ps
module matrix_keyboard_decoder_top import mkd_pkg::*; #(
  parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [3:0] in_row_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_column_drive,
  output logic       out_char_valid,
  output logic [7:0] out_char_byte,
  output logic       out_shift_active,
  output logic       out_alt_active,
  output logic       out_last
);

  logic in_take;
  logic busy;
  rec_t rec;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;

  mkd_decode #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .func     (in_func),
    .row_line (in_row_line),
    .rec      (rec)
  );

  mkd_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (in_take),
    .rec_in           (rec),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_column_drive (out_column_drive),
    .out_char_valid   (out_char_valid),
    .out_char_byte    (out_char_byte),
    .out_shift_active (out_shift_active),
    .out_alt_active   (out_alt_active),
    .out_last         (out_last)
  );

endmodule

// ===== src/mkd_decode.sv =====
// Scan state, modifier state and key lookup for one accepted beat.
`timescale 1ns / 1ps
module mkd_decode import mkd_pkg::*; #(
  parameter int LINE_COUNT_BITS = LINE_COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       func,
  input  logic [3:0] row_line,
  output rec_t       rec
);

  logic [2:0]                 column_r, column_nxt;
  logic                       seen_r, seen_nxt;
  logic                       released_r, released_nxt;
  logic                       shift_r, shift_nxt;
  logic                       alt_r, alt_nxt;
  logic [LINE_COUNT_BITS-1:0] count_r, count_nxt;
  logic [2:0]                 col_idx;
  logic [7:0]                 base_c, alt_c, code;
  logic [1:0]                 kind;
  logic [7:0]                 chr;

  assign col_idx = column_r - 3'd1;
  assign base_c  = base_code(row_line[2:0], col_idx);
  assign alt_c   = alt_code(row_line[2:0], col_idx);
  assign code    = (alt_r && alt_c != KC_NONE) ? alt_c : base_c;

  always_comb begin
    column_nxt   = column_r;
    seen_nxt     = seen_r;
    released_nxt = released_r;
    shift_nxt    = shift_r;
    alt_nxt      = alt_r;
    count_nxt    = count_r;
    kind         = KIND_NONE;
    chr          = KC_NONE;
    if (!func) begin
      if (column_r >= COL_LAST) begin
        column_nxt   = COL_FIRST;
        released_nxt = !seen_r;
        seen_nxt     = 1'b0;
      end else begin
        column_nxt = column_r + 3'd1;
      end
    end else if (row_line <= ROW_LAST && !seen_r) begin
      seen_nxt = 1'b1;
      if (released_r) begin
        case (code)
          KC_SHIFT: begin
            shift_nxt = !shift_r;
            alt_nxt   = 1'b0;
          end
          KC_ALT: begin
            alt_nxt   = 1'b1;
            shift_nxt = 1'b0;
          end
          KC_NOP: begin
          end
          KC_DEL: begin
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
              shift_nxt = 1'b0;
              alt_nxt   = 1'b0;
              kind      = KIND_DEL;
            end
          end
          KC_ENTER: begin
            count_nxt = '0;
            shift_nxt = 1'b0;
            alt_nxt   = 1'b0;
            kind      = KIND_ENTER;
          end
          default: begin
            chr = code;
            if (shift_r && (code inside {["a":"z"]})) begin
              chr = code - CASE_OFFSET;
            end
            if (count_r != '1) begin
              count_nxt = count_r + 1'b1;
            end
            shift_nxt = 1'b0;
            alt_nxt   = 1'b0;
            kind      = KIND_CHAR;
          end
        endcase
      end
    end
  end

  assign rec.kind   = kind;
  assign rec.chr    = chr;
  assign rec.column = column_nxt;
  assign rec.shift  = shift_nxt;
  assign rec.alt    = alt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= COL_FIRST;
      seen_r     <= 1'b0;
      released_r <= 1'b1;
      shift_r    <= 1'b0;
      alt_r      <= 1'b0;
      count_r    <= '0;
    end else if (take) begin
      column_r   <= column_nxt;
      seen_r     <= seen_nxt;
      released_r <= released_nxt;
      shift_r    <= shift_nxt;
      alt_r      <= alt_nxt;
      count_r    <= count_nxt;
    end
  end

endmodule

// ===== src/mkd_emit.sv =====
// Result register that sends the bytes of one record, one beat per byte.
`timescale 1ns / 1ps
`include "matrix_keyboard_decoder_top_macros.svh"
module mkd_emit import mkd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  rec_t       rec_in,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_column_drive,
  output logic       out_char_valid,
  output logic [7:0] out_char_byte,
  output logic       out_shift_active,
  output logic       out_alt_active,
  output logic       out_last
);

  rec_t       rec_r;
  logic       valid_r;
  logic [1:0] idx_r;
  logic [1:0] last_idx;
  logic       is_last;
  logic       take;

  always_comb begin
    case (rec_r.kind)
      KIND_DEL:   last_idx = 2'd2;
      KIND_ENTER: last_idx = 2'd1;
      default:    last_idx = 2'd0;
    endcase
  end

  always_comb begin
    case (rec_r.kind)
      KIND_CHAR:  out_char_byte = rec_r.chr;
      KIND_ENTER: out_char_byte = (idx_r == 2'd0) ? CH_CR : CH_LF;
      KIND_DEL:   out_char_byte = (idx_r == 2'd1) ? CH_SP : CH_BS;
      default:    out_char_byte = KC_NONE;
    endcase
  end

  assign is_last = (idx_r == last_idx);
  assign take    = valid_r && !out_stall;
  // The register frees up in the cycle its final byte leaves.
  assign busy    = valid_r && !(take && is_last);

  assign out_valid        = valid_r;
  assign out_column_drive = rec_r.column;
  assign out_char_valid   = (rec_r.kind != KIND_NONE);
  assign out_shift_active = rec_r.shift;
  assign out_alt_active   = rec_r.alt;
  assign out_last         = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (take) begin
      if (is_last) begin
        valid_r <= 1'b0;
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec_in;
    end
  end

  `MKD_ASSERT(a_idx_range, !valid_r || idx_r <= last_idx, "byte index past record end")
  `MKD_ASSERT_NEXT(a_load_start, load, valid_r && idx_r == 2'd0, "record not started after load")
  `MKD_ASSERT_NEXT(a_drain, take && is_last && !load, !valid_r, "record held after final byte")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the key matrix decoder: scan rules, key strokes and stalls.
`timescale 1ns / 1ps
module tb_top;
  import mkd_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_LEN = 300;
  localparam int ITEMS_PER_PHASE = 100;

  // Key maps, one character per key, row by row. Upper-case letters mark the action keys.
  localparam logic [7:0] KEY_SHIFT = "S";
  localparam logic [7:0] KEY_DEL = "D";
  localparam logic [7:0] KEY_ALT = "A";
  localparam logic [7:0] KEY_NOP = "N";
  localparam logic [7:0] KEY_ENTER = "E";
  localparam logic [7:0] KEY_NO_ALT = "~";
  localparam logic [35*8-1:0] BASE_KEYS = "qeruowsghlNdtyiapSEDAxvb$ zcnmNSfjk";
  localparam logic [35*8-1:0] ALT_KEYS = "#23_+14/:\"~5()-*@~~~~8?!~~79,.0~6;'";

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_SP = 8'h20;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] UPPER_OFFSET = 8'h20;

  // Key positions (row 0..6, column 1..5) of the action keys.
  localparam int ROW_ALT = 4, COL_ALT = 1;
  localparam int ROW_LSHIFT = 3, COL_LSHIFT = 3;
  localparam int ROW_RSHIFT = 6, COL_RSHIFT = 2;
  localparam int ROW_ENTER = 3, COL_ENTER = 4;
  localparam int ROW_DEL = 3, COL_DEL = 5;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  typedef struct packed {
    logic [2:0] column;
    logic       char_valid;
    logic [7:0] char_byte;
    logic       shift;
    logic       alt;
    logic       last;
  } key_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_func = 1'b0;
  logic [3:0] in_row_line = 4'd0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] out_column_drive;
  logic       out_char_valid;
  logic [7:0] out_char_byte;
  logic       out_shift_active;
  logic       out_alt_active;
  logic       out_last;

  // Predicted decoder state.
  logic [2:0]  pred_column;
  logic        pred_row_seen;
  logic        pred_released;
  logic        pred_shift;
  logic        pred_alt;
  logic [15:0] pred_line_count;

  key_beat_t due_beats[$];
  int fail_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stim_col = 1;

  matrix_keyboard_decoder_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_row_line(in_row_line),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_column_drive(out_column_drive),
    .out_char_valid(out_char_valid),
    .out_char_byte(out_char_byte),
    .out_shift_active(out_shift_active),
    .out_alt_active(out_alt_active),
    .out_last(out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] key_at(input logic [35*8-1:0] keys, input int idx);
    return keys[(34 - idx) * 8 +: 8];
  endfunction

  function automatic void push_beat(input logic valid, input logic [7:0] b, input logic last);
    key_beat_t beat;
    beat.column = pred_column;
    beat.char_valid = valid;
    beat.char_byte = b;
    beat.shift = pred_shift;
    beat.alt = pred_alt;
    beat.last = last;
    due_beats.push_back(beat);
  endfunction

  function automatic void decode_key_event(input logic func, input logic [3:0] line);
    logic [2:0][7:0] bytes;
    logic [7:0] code;
    logic [7:0] alt_code;
    int n;
    int idx;
    n = 0;
    bytes = '0;
    if (func == FUNC_TICK) begin
      if (pred_column >= 3'd5) begin
        pred_released = !pred_row_seen;
        pred_column = 3'd1;
        pred_row_seen = 1'b0;
      end else begin
        pred_column = pred_column + 3'd1;
      end
    end else if (line <= 4'd6 && !pred_row_seen) begin
      pred_row_seen = 1'b1;
      if (pred_released) begin
        idx = int'(line) * 5 + int'(pred_column) - 1;
        code = key_at(BASE_KEYS, idx);
        alt_code = key_at(ALT_KEYS, idx);
        if (pred_alt && alt_code != KEY_NO_ALT) code = alt_code;
        case (code)
          KEY_SHIFT: begin
            pred_shift = !pred_shift;
            pred_alt = 1'b0;
          end
          KEY_ALT: begin
            pred_alt = 1'b1;
            pred_shift = 1'b0;
          end
          KEY_NOP: ;
          KEY_DEL: begin
            if (pred_line_count != 16'd0) begin
              pred_line_count = pred_line_count - 16'd1;
              pred_shift = 1'b0;
              pred_alt = 1'b0;
              bytes[0] = BYTE_BS;
              bytes[1] = BYTE_SP;
              bytes[2] = BYTE_BS;
              n = 3;
            end
          end
          KEY_ENTER: begin
            pred_line_count = 16'd0;
            pred_shift = 1'b0;
            pred_alt = 1'b0;
            bytes[0] = BYTE_CR;
            bytes[1] = BYTE_LF;
            n = 2;
          end
          default: begin
            if (pred_shift && code >= "a" && code <= "z") code = code - UPPER_OFFSET;
            if (pred_line_count != 16'hFFFF) pred_line_count = pred_line_count + 16'd1;
            pred_shift = 1'b0;
            pred_alt = 1'b0;
            bytes[0] = code;
            n = 1;
          end
        endcase
      end
    end
    if (n == 0) begin
      push_beat(1'b0, 8'd0, 1'b1);
    end else begin
      for (int k = 0; k < n; k++) push_beat(1'b1, bytes[k], k == n - 1);
    end
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
    end
  endfunction

  // Predicts on every accepted input beat, then checks every accepted result beat.
  always @(posedge clk) begin : track
    key_beat_t want;
    if (!rst_n) begin
      pred_column = 3'd1;
      pred_row_seen = 1'b0;
      pred_released = 1'b1;
      pred_shift = 1'b0;
      pred_alt = 1'b0;
      pred_line_count = 16'd0;
      due_beats.delete();
    end else begin
      if (in_valid && !in_stall) decode_key_event(in_func, in_row_line);
      if (out_valid && !out_stall) begin
        if (due_beats.size() == 0) begin
          $error("result beat with nothing expected: byte 0x%0h", out_char_byte);
          fail_count++;
        end else begin
          want = due_beats.pop_front();
          check_field("column_drive", 8'(want.column), 8'(out_column_drive));
          check_field("char_valid", 8'(want.char_valid), 8'(out_char_valid));
          check_field("char_byte", want.char_byte, out_char_byte);
          check_field("shift_active", 8'(want.shift), 8'(out_shift_active));
          check_field("alt_active", 8'(want.alt), 8'(out_alt_active));
          check_field("last", 8'(want.last), 8'(out_last));
        end
      end
    end
  end

  // Result side: random stalls, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_served != hold_asks) begin
      hold_served <= hold_asks;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_event(input logic func, input logic [3:0] line);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_row_line <= line;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // The row line is a don't-care on a tick, so it carries random noise.
  task automatic send_tick();
    send_event(FUNC_TICK, 4'($urandom_range(15)));
    stim_col = (stim_col == 5) ? 1 : stim_col + 1;
  endtask

  task automatic send_noise();
    if ($urandom_range(1) == 0) send_tick();
    else send_event(FUNC_EDGE, 4'($urandom_range(15)));
  endtask

  // One key stroke: press at the key's column, finish the scan, then ticks so an unheld key
  // counts as released again. Bounce adds later edges; holding adds one in the next scan.
  task automatic strike_key(input int row, input int col, input bit bounce, input bit held);
    while (stim_col != col) send_tick();
    send_event(FUNC_EDGE, 4'(row));
    if (bounce) repeat ($urandom_range(2, 1)) send_event(FUNC_EDGE, 4'($urandom_range(15)));
    do send_tick(); while (stim_col != 1);
    if (held) send_event(FUNC_EDGE, 4'($urandom_range(6)));
    repeat (5) send_tick();
  endtask

  task automatic strike_random_key();
    int pick;
    int row;
    int col;
    pick = $urandom_range(99);
    row = $urandom_range(6);
    col = $urandom_range(5, 1);
    if (pick < 15) begin
      row = ROW_ALT;
      col = COL_ALT;
    end else if (pick < 23) begin
      row = ROW_LSHIFT;
      col = COL_LSHIFT;
    end else if (pick < 30) begin
      row = ROW_RSHIFT;
      col = COL_RSHIFT;
    end else if (pick < 40) begin
      row = ROW_ENTER;
      col = COL_ENTER;
    end else if (pick < 50) begin
      row = ROW_DEL;
      col = COL_DEL;
    end
    strike_key(row, col, $urandom_range(9) == 0, $urandom_range(9) == 0);
  endtask

  // The last beat has been taken, so the sender goes idle before waiting.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Ignored lines, first and later edges, a held key, and delete at the last column.
  task automatic test_scan_rules();
    sender_idle_pct = 0;
    stall_pct = 0;
    send_event(FUNC_EDGE, 4'd15);
    send_event(FUNC_EDGE, 4'd0);
    send_event(FUNC_EDGE, 4'd6);
    repeat (5) send_tick();
    send_event(FUNC_EDGE, 4'd3);
    repeat (10) send_tick();
    strike_key(ROW_DEL, COL_DEL, 1'b0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_strokes(input int idle_pct, input int stall_rate);
    int goal;
    sender_idle_pct = idle_pct;
    stall_pct = stall_rate;
    goal = items_sent + ITEMS_PER_PHASE;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 80) strike_random_key();
      else send_noise();
    end
    wait_drained();
  endtask

  // The receiver holds off while the sender keeps offering beats, so the input backs up.
  task automatic test_output_hold();
    int goal;
    sender_idle_pct = 0;
    stall_pct = 0;
    hold_asks++;
    goal = items_sent + 40;
    while (items_sent < goal) strike_random_key();
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_scan_rules();
    test_random_strokes(0, 0);
    test_random_strokes(83, 0);
    test_random_strokes(0, 83);
    test_random_strokes(7, 7);
    test_output_hold();
    wait_drained();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== matrix_keyboard_decoder_top.f =====
+incdir+src
src/mkd_pkg.sv
src/mkd_decode.sv
src/mkd_emit.sv
src/matrix_keyboard_decoder_top.sv
verif/tb_top.sv
